// ===== design/skac_pkg.sv =====
// Package for the scheduled key access checker: sizes, codes, command and status types.
package skac_pkg;

	localparam int USER_AW = 8;
	localparam int SLOT_AW = 6;
	localparam int BOUND_AW = USER_AW + SLOT_AW;
	localparam int USER_DEPTH = 1 << USER_AW;
	localparam int BOUND_SLOTS = 1 << SLOT_AW;
	localparam int UCNT_W = USER_AW + 1;

	// Register index of user_count, taken from paddr[2].
	localparam logic REG_USER_COUNT = 1'b0;

	localparam logic [6:0] FIRST_YEAR = 7'd18;
	localparam logic [6:0] CENTURY_YEAR = 7'd100;
	localparam logic [31:0] ODD_WEEK_MINUTES = 32'd10080;
	localparam logic [31:0] MINUTES_PER_DAY = 32'd1440;
	localparam logic [31:0] MINUTES_PER_HOUR = 32'd60;

	typedef enum logic [1:0] {
		ACT_CHECK    = 2'd0,
		ACT_WR_KEY   = 2'd1,
		ACT_WR_BOUND = 2'd2,
		ACT_WR_FLAG  = 2'd3
	} skac_action_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY_RD,
		ST_KEY_CMP,
		ST_YEAR,
		ST_MONTH,
		ST_MINUTE,
		ST_BND_RD,
		ST_BND_CMP,
		ST_RESP
	} skac_state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic key_rd;
		logic key_cmp;
		logic year_step;
		logic month_step;
		logic minute_calc;
		logic bnd_rd;
		logic bnd_cmp;
		logic out_load;
	} skac_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_check;
		logic n_zero;
		logic key_hit;
		logic key_last;
		logic year_done;
		logic month_done;
		logic bnd_last;
		logic out_free;
	} skac_status_t;

	// Leap test for year-2000 in the range of a 7-bit field.
	function automatic logic is_leap(input logic [6:0] y);
		return (y[1:0] == 2'b00) && (y != CENTURY_YEAR);
	endfunction

	// Reduce a small value modulo 14 by repeated subtraction.
	function automatic logic [5:0] mod14(input logic [5:0] v);
		logic [5:0] r;
		r = v;
		for (int i = 0; i < 4; i++) begin
			if (r >= 6'd14) begin
				r = r - 6'd14;
			end
		end
		return r;
	endfunction

endpackage

// ===== design/scheduled_key_access_check_top.sv =====
// Top level of the scheduled key access checker: configuration port and block wiring.
//
// Requests enter on the in_valid / in_stall channel and carry an action code with
// its operands. Write actions load a user key, one boundary minute or one first-range
// flag; a check action looks up the presented key and decides on access for the
// given date and time. Every request yields exactly one result on out_valid /
// out_stall (granted, key_found); writes always answer with both bits low.
// A write request goes from acceptance straight to the response state. A check reads
// and compares the key store entry by entry up to the match (one store read and one
// compare per entry); on a miss it goes to the response state at once. After a match
// it counts the years after 2018 and the months before the date, works out the minute
// of the two-week cycle, reads and compares the 64 boundary slots and loads the result.
// One request is in work at a time; in_stall is high until its result is written
// to the output register. A result held by out_stall does not block acceptance of
// the next request, but that request's result waits until the held one is taken.
// After reset the boundary tables and flags are cleared, during which in_stall stays
// high; the user_count register may be written then.
// user_count sits at byte address 0 of the APB port, which is always ready.
module scheduled_key_access_check_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  user_index,
	input  logic        side,
	input  logic [5:0]  slot_index,
	input  logic [31:0] write_value,
	input  logic [31:0] key,
	input  logic [6:0]  year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [2:0]  weekday,
	input  logic [4:0]  hours,
	input  logic [5:0]  minutes,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        granted,
	output logic        key_found
);
	import skac_pkg::*;

	logic [8:0] user_count_q;
	skac_cmd_t cmd;
	skac_status_t sts;

	// The register takes a write only in the access phase at its own address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_count_q <= 9'd0;
		end else if (psel && penable && pwrite && (paddr[2] == REG_USER_COUNT)) begin
			user_count_q <= pwdata[8:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_USER_COUNT) ? {23'd0, user_count_q} : 32'd0;

	skac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	skac_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.user_count  (user_count_q),
		.action      (action),
		.user_index  (user_index),
		.side        (side),
		.slot_index  (slot_index),
		.write_value (write_value),
		.key         (key),
		.year        (year),
		.month       (month),
		.day         (day),
		.weekday     (weekday),
		.hours       (hours),
		.minutes     (minutes),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.granted     (granted),
		.key_found   (key_found)
	);

endmodule

// ===== design/skac_ctrl.sv =====
// Controller state machine of the scheduled key access checker.
module skac_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  skac_pkg::skac_status_t sts,
	output skac_pkg::skac_cmd_t   cmd
);
	import skac_pkg::*;

	skac_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (sts.is_check && !sts.n_zero) begin
						state_d = ST_KEY_RD;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_KEY_RD: begin
				cmd.key_rd = 1'b1;
				state_d = ST_KEY_CMP;
			end
			ST_KEY_CMP: begin
				cmd.key_cmp = 1'b1;
				if (sts.key_hit) begin
					state_d = ST_YEAR;
				end else if (sts.key_last) begin
					state_d = ST_RESP;
				end else begin
					state_d = ST_KEY_RD;
				end
			end
			ST_YEAR: begin
				if (sts.year_done) begin
					state_d = ST_MONTH;
				end else begin
					cmd.year_step = 1'b1;
				end
			end
			ST_MONTH: begin
				if (sts.month_done) begin
					state_d = ST_MINUTE;
				end else begin
					cmd.month_step = 1'b1;
				end
			end
			ST_MINUTE: begin
				cmd.minute_calc = 1'b1;
				state_d = ST_BND_RD;
			end
			ST_BND_RD: begin
				cmd.bnd_rd = 1'b1;
				state_d = ST_BND_CMP;
			end
			ST_BND_CMP: begin
				cmd.bnd_cmp = 1'b1;
				state_d = sts.bnd_last ? ST_RESP : ST_BND_RD;
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== design/skac_datapath.sv =====
// Datapath of the scheduled key access checker: stores, counters and result register.
module skac_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skac_pkg::skac_cmd_t   cmd,
	output skac_pkg::skac_status_t sts,
	input  logic [8:0]            user_count,
	input  logic [1:0]            action,
	input  logic [7:0]            user_index,
	input  logic                  side,
	input  logic [5:0]            slot_index,
	input  logic [31:0]           write_value,
	input  logic [31:0]           key,
	input  logic [6:0]            year,
	input  logic [3:0]            month,
	input  logic [4:0]            day,
	input  logic [2:0]            weekday,
	input  logic [4:0]            hours,
	input  logic [5:0]            minutes,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  granted,
	output logic                  key_found
);
	import skac_pkg::*;

	logic [31:0] key_mem [USER_DEPTH];
	logic flag_ex_mem [USER_DEPTH];
	logic flag_en_mem [USER_DEPTH];
	logic [15:0] bnd_en_mem [1 << BOUND_AW];
	logic [15:0] bnd_ex_mem [1 << BOUND_AW];

	logic side_q;
	logic [31:0] key_q;
	logic [6:0] year_q;
	logic [3:0] month_q;
	logic [4:0] day_q;
	logic [2:0] wday_q;
	logic [4:0] hours_q;
	logic [5:0] mins_q;

	logic [BOUND_AW-1:0] clr_cnt_q;
	logic [UCNT_W-1:0] ucnt_q, n_users;
	logic [31:0] key_rd_q;
	logic hit_q;
	logic [6:0] yc_q;
	logic [3:0] mc_q;
	logic [5:0] dm_q;
	logic nz_q;
	logic [31:0] min_q;
	logic flag_rd_q;
	logic [SLOT_AW-1:0] slot_q, idx_q;
	logic [15:0] best_q, bnd_rd_q;
	logic out_valid_q, granted_q, found_q;

	logic wr_key, wr_bnd, wr_flag;
	logic [5:0] month_add, year_add, par_r;
	logic week_odd, flag_bit;
	logic [BOUND_AW-1:0] bnd_addr;

	assign wr_key  = cmd.load && (action == ACT_WR_KEY);
	assign wr_bnd  = cmd.load && (action == ACT_WR_BOUND);
	assign wr_flag = cmd.load && (action == ACT_WR_FLAG);

	assign n_users = (user_count > UCNT_W'(USER_DEPTH)) ? UCNT_W'(USER_DEPTH) : user_count;
	assign bnd_addr = {ucnt_q[USER_AW-1:0], slot_q};

	always_comb begin
		year_add = is_leap(yc_q) ? 6'd2 : 6'd1;
		if (mc_q <= 4'd7) begin
			if (mc_q == 4'd2) begin
				month_add = is_leap(year_q) ? 6'd1 : 6'd0;
			end else begin
				month_add = mc_q[0] ? 6'd3 : 6'd2;
			end
		end else begin
			month_add = mc_q[0] ? 6'd2 : 6'd3;
		end
		// Days before the date plus day minus one, modulo two weeks.
		par_r = mod14(dm_q + {1'b0, day_q} + 6'd13);
		week_odd = (nz_q || (day_q != 5'd0)) && (par_r >= 6'd7);
		flag_bit = flag_rd_q;
	end

	always_ff @(posedge clk) begin
		if (wr_key) begin
			key_mem[user_index] <= write_value;
		end
		if (cmd.key_rd) begin
			key_rd_q <= key_mem[ucnt_q[USER_AW-1:0]];
		end
	end

	// The flags are cleared together with the boundary tables after reset.
	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			flag_ex_mem[clr_cnt_q[USER_AW-1:0]] <= 1'b0;
			flag_en_mem[clr_cnt_q[USER_AW-1:0]] <= 1'b0;
		end else begin
			if (wr_flag && !side) begin
				flag_ex_mem[user_index] <= write_value[0];
			end
			if (wr_flag && side) begin
				flag_en_mem[user_index] <= write_value[0];
			end
		end
		if (cmd.minute_calc) begin
			flag_rd_q <= side_q ? flag_en_mem[ucnt_q[USER_AW-1:0]]
			                    : flag_ex_mem[ucnt_q[USER_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			bnd_en_mem[clr_cnt_q] <= 16'd0;
		end else if (wr_bnd && side) begin
			bnd_en_mem[{user_index, slot_index}] <= write_value[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			bnd_ex_mem[clr_cnt_q] <= 16'd0;
		end else if (wr_bnd && !side) begin
			bnd_ex_mem[{user_index, slot_index}] <= write_value[15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bnd_rd) begin
			bnd_rd_q <= side_q ? bnd_en_mem[bnd_addr] : bnd_ex_mem[bnd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			side_q  <= side;
			key_q   <= key;
			year_q  <= year;
			month_q <= month;
			day_q   <= day;
			wday_q  <= weekday;
			hours_q <= hours;
			mins_q  <= minutes;
		end
		if (cmd.load) begin
			yc_q <= FIRST_YEAR;
			mc_q <= 4'd1;
			dm_q <= 6'd0;
			nz_q <= 1'b0;
		end else if (cmd.year_step) begin
			yc_q <= yc_q + 7'd1;
			dm_q <= mod14(dm_q + year_add);
			nz_q <= 1'b1;
		end else if (cmd.month_step) begin
			mc_q <= mc_q + 4'd1;
			dm_q <= mod14(dm_q + month_add);
			nz_q <= 1'b1;
		end
		if (cmd.minute_calc) begin
			min_q <= (week_odd ? 32'd0 : ODD_WEEK_MINUTES)
			       + ({29'd0, wday_q} - 32'd1) * MINUTES_PER_DAY
			       + {27'd0, hours_q} * MINUTES_PER_HOUR
			       + {26'd0, mins_q};
			slot_q <= '0;
			best_q <= 16'd0;
			idx_q  <= '0;
		end else if (cmd.bnd_cmp) begin
			if ((bnd_rd_q > best_q) && ({16'd0, bnd_rd_q} < min_q)) begin
				best_q <= bnd_rd_q;
				idx_q  <= slot_q;
			end
			slot_q <= slot_q + SLOT_AW'(1);
		end
		if (cmd.out_load) begin
			granted_q <= hit_q && (idx_q[0] ? flag_bit : !flag_bit);
			found_q   <= hit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			ucnt_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_cnt_q <= clr_cnt_q + BOUND_AW'(1);
			end
			if (cmd.load) begin
				ucnt_q <= '0;
				hit_q  <= 1'b0;
			end else if (cmd.key_cmp) begin
				if (key_rd_q == key_q) begin
					hit_q <= 1'b1;
				end else begin
					ucnt_q <= ucnt_q + UCNT_W'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clr_last   = (clr_cnt_q == '1);
		sts.is_check   = (action == ACT_CHECK);
		sts.n_zero     = (n_users == '0);
		sts.key_hit    = (key_rd_q == key_q);
		sts.key_last   = (ucnt_q == n_users - UCNT_W'(1));
		sts.year_done  = (yc_q >= year_q);
		sts.month_done = (mc_q >= month_q);
		sts.bnd_last   = (slot_q == '1);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	assign out_valid = out_valid_q;
	assign granted   = granted_q;
	assign key_found = found_q;

endmodule
